### hw/rtl/stop_and_wait_arq_server_unit_defines.svh
// Assertion helpers for the ARQ server
`ifndef STOP_AND_WAIT_ARQ_SERVER_UNIT_DEFINES_SVH
`define STOP_AND_WAIT_ARQ_SERVER_UNIT_DEFINES_SVH

`define SAW_ASSERT_IMP(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("assertion failed");

`define SAW_ASSERT_NXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

### hw/rtl/sawarq_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package sawarq_pkg;
    localparam int unsigned ADDR_W = 48;
    localparam int unsigned SEQ_W  = 32;
    localparam int unsigned TMO_W  = 16;
    localparam logic [TMO_W-1:0] RESET_TIMEOUT = 16'd500;
    localparam logic [SEQ_W-1:0] START_SEQ = 32'd1;
    localparam int unsigned MAX_RESULTS = 8;

    typedef enum logic [2:0] {
        CMD_SYN = 3'd0, CMD_ACK = 3'd1, CMD_DATA = 3'd2, CMD_TICK = 3'd3,
        CMD_SEND = 3'd4, CMD_ACCEPT = 3'd5, CMD_CLOSE = 3'd6, CMD_NONE = 3'd7
    } cmd_t;

    typedef enum logic [3:0] {
        K_SYN_QUEUED = 4'd0, K_SYN_DROPPED = 4'd1, K_UNKNOWN = 4'd2,
        K_ACK_TAKEN = 4'd3, K_DELIVER = 4'd4, K_SEND_ACK = 4'd5,
        K_TRANSMIT = 4'd6, K_IDLE = 4'd7, K_QUEUED = 4'd8, K_SEND_REJ = 4'd9,
        K_NONE_PEND = 4'd10, K_TABLE_FULL = 4'd11, K_ADMITTED = 4'd12,
        K_CLOSED = 4'd13, K_CLOSE_REJ = 4'd14, K_RSVD = 4'd15
    } kind_t;

    typedef struct packed {
        logic [3:0]        kind;
        logic [ADDR_W-1:0] addr;
        logic [SEQ_W-1:0]  seq;
        logic [2:0]        slot;
        logic              last;
    } result_t;
endpackage
`default_nettype wire

### hw/rtl/sawarq_out_reg.sv
`timescale 1ns / 1ps
`default_nettype none
// One-entry result holding register toward the output channel
module sawarq_out_reg (
    input  wire                    aclk,
    input  wire                    aresetn,
    input  wire                    in_valid,
    output logic                   in_ready,
    input  sawarq_pkg::result_t    in_data,
    output logic                   out_valid,
    input  wire                    out_ready,
    output sawarq_pkg::result_t    out_data
);
    logic                valid_reg;
    sawarq_pkg::result_t data_reg;

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
        if (in_ready && in_valid) begin
            data_reg <= in_data;
        end
    end
endmodule
`default_nettype wire

### hw/rtl/stop_and_wait_arq_server_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// Stop-and-wait ARQ server engine.
// s_axis: one command item per transfer; tdata = {client_slot, seq_id, peer_addr},
//   tuser = cmd. s_axis_tready is high only while the sequencer is idle.
// m_axis: result items; tdata = {out_slot, out_seq, out_addr}, tuser = kind,
//   tlast marks the final result of a command.
// cfg_we/cfg_wdata write ack_timeout_ms (reset value 500).
// A sequencer walks the client slots one per cycle through one shared
// comparator/subtractor; a tick scan pauses while it emits a transmit. Syn,
// send and close go from idle through exec and emit; ack, data and accept
// first scan until a hit or the end of the table, then exec and emit (data
// emits a second result when it delivers); tick scans the slots and emits
// each held transmit when the next one is found or the scan ends. Each
// result leaves its emit state through a one-entry output register.
// When m_axis_tready is low the sequencer holds with its result pending and
// the slot scan pauses; nothing is lost.
// Reset (synchronous, aresetn low) clears the slot valid bits, the SYN queue
// head and fill and the millisecond clock, and loads 500 into the timeout
// register; no clearing pass.
module stop_and_wait_arq_server_unit #(
    parameter int CLIENTS   = 8,
    parameter int TX_DEPTH  = 16,
    parameter int SYN_DEPTH = 4
) (
    input  wire          aclk,
    input  wire          aresetn,
    input  wire          s_axis_tvalid,
    output logic         s_axis_tready,
    input  wire  [87:0]  s_axis_tdata,  // peer_addr[47:0], seq_id[79:48], client_slot[82:80]
    input  wire  [2:0]   s_axis_tuser,  // cmd
    output logic         m_axis_tvalid,
    input  wire          m_axis_tready,
    output logic [87:0]  m_axis_tdata,  // out_addr[47:0], out_seq[79:48], out_slot[82:80]
    output logic [3:0]   m_axis_tuser,  // kind
    output logic         m_axis_tlast,
    input  wire          cfg_we,
    input  wire  [15:0]  cfg_wdata
);
    localparam int SW = (CLIENTS > 1) ? $clog2(CLIENTS) : 1;
    localparam int QW = (SYN_DEPTH > 1) ? $clog2(SYN_DEPTH) : 1;
    localparam int FW = $clog2(SYN_DEPTH + 1);
    localparam int FW1 = FW + 1;
    localparam int TW = $clog2(TX_DEPTH + 1);
    localparam int CW = $clog2(CLIENTS + 1);
    localparam int NW = $clog2(sawarq_pkg::MAX_RESULTS + 1);
    localparam int AW = sawarq_pkg::ADDR_W;
    localparam int QSW = sawarq_pkg::SEQ_W;

    typedef enum logic [2:0] {
        ST_IDLE, ST_SCAN, ST_EXEC, ST_EMIT, ST_EMIT2
    } state_t;

    state_t state_reg;

    logic [15:0]    tmo_reg;
    logic [QSW-1:0] now_reg;
    logic [CLIENTS-1:0] valid_reg;
    logic [AW-1:0]  addr_mem [CLIENTS];
    logic [QSW-1:0] rxe_mem  [CLIENTS];
    logic [QSW-1:0] txn_mem  [CLIENTS];
    logic [TW-1:0]  txc_mem  [CLIENTS];
    logic           await_mem[CLIENTS];
    logic [QSW-1:0] lst_mem  [CLIENTS];
    logic [AW-1:0]  syn_mem  [SYN_DEPTH];
    logic [QW-1:0]  head_reg;
    logic [FW-1:0]  fill_reg;

    sawarq_pkg::cmd_t cmd_reg;
    logic [AW-1:0]  paddr_reg;
    logic [QSW-1:0] pseq_reg;
    logic [2:0]     cslot_reg;
    logic [CW-1:0]  idx_reg;
    logic           found_reg;
    logic [SW-1:0]  hit_reg;
    logic [NW-1:0]  nres_reg;
    sawarq_pkg::result_t res_reg, res2_reg;

    logic                res_valid;
    logic                res_ready;
    sawarq_pkg::result_t res_data;
    sawarq_pkg::result_t res_data_o;

    sawarq_out_reg u_out (
        .aclk(aclk), .aresetn(aresetn),
        .in_valid(res_valid), .in_ready(res_ready), .in_data(res_data),
        .out_valid(m_axis_tvalid), .out_ready(m_axis_tready), .out_data(res_data_o)
    );

    assign m_axis_tdata = {5'd0, res_data_o.slot, res_data_o.seq, res_data_o.addr};
    assign m_axis_tuser = res_data_o.kind;
    assign m_axis_tlast = res_data_o.last;

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign res_valid = (state_reg == ST_EMIT) || (state_reg == ST_EMIT2);
    assign res_data  = (state_reg == ST_EMIT2) ? res2_reg : res_reg;

    // SYN queue write slot wrapped by compare and subtract, head advance wrapped to zero by compare
    logic [FW1-1:0] wr_sum;
    logic [QW-1:0]  wr_ix;
    logic [QW-1:0]  head_inc;
    assign wr_sum   = FW1'(head_reg) + FW1'(fill_reg);
    assign wr_ix    = (wr_sum >= FW1'(SYN_DEPTH)) ? QW'(wr_sum - FW1'(SYN_DEPTH)) :
                                                    QW'(wr_sum);
    assign head_inc = (head_reg == QW'(SYN_DEPTH - 1)) ? '0 : head_reg + 1'b1;

    // shared slot probe at the scan index
    logic [SW-1:0]  ix;
    logic           probe_hit;
    logic [QSW-1:0] age;
    logic           in_rng;
    assign ix     = idx_reg[SW-1:0];
    assign in_rng = (idx_reg < CW'(CLIENTS));
    assign age    = now_reg - lst_mem[ix];
    always_comb begin
        probe_hit = 1'b0;
        unique case (cmd_reg)
            sawarq_pkg::CMD_ACK, sawarq_pkg::CMD_DATA:
                probe_hit = valid_reg[ix] && (addr_mem[ix] == paddr_reg);
            sawarq_pkg::CMD_ACCEPT:
                probe_hit = !valid_reg[ix];
            sawarq_pkg::CMD_TICK:
                probe_hit = valid_reg[ix] && (txc_mem[ix] != '0) &&
                            (!await_mem[ix] || (age >= QSW'(tmo_reg)));
            default: probe_hit = 1'b0;
        endcase
    end

    function automatic sawarq_pkg::result_t mk(sawarq_pkg::kind_t k, logic [AW-1:0] a,
                                               logic [QSW-1:0] s, logic [2:0] sl,
                                               logic l);
        sawarq_pkg::result_t r;
        r.kind = k; r.addr = a; r.seq = s; r.slot = sl; r.last = l;
        return r;
    endfunction

    logic [2:0]  cs_q;
    logic [SW-1:0] cs_ix;
    logic        cs_ok;
    assign cs_q  = cslot_reg;
    assign cs_ix = SW'(cs_q);
    assign cs_ok = ({1'b0, cs_q} < 4'(CLIENTS)) && valid_reg[cs_ix];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            tmo_reg   <= sawarq_pkg::RESET_TIMEOUT;
            now_reg   <= '0;
            valid_reg <= '0;
            head_reg  <= '0;
            fill_reg  <= '0;
        end else begin
            if (cfg_we) tmo_reg <= cfg_wdata;
            unique case (state_reg)
                ST_IDLE: begin
                    if (s_axis_tvalid) begin
                        cmd_reg   <= sawarq_pkg::cmd_t'(s_axis_tuser);
                        paddr_reg <= s_axis_tdata[47:0];
                        pseq_reg  <= s_axis_tdata[79:48];
                        cslot_reg <= s_axis_tdata[82:80];
                        idx_reg   <= '0;
                        found_reg <= 1'b0;
                        nres_reg  <= '0;
                        if (sawarq_pkg::cmd_t'(s_axis_tuser) == sawarq_pkg::CMD_TICK)
                            now_reg <= now_reg + 1'b1;
                        if (sawarq_pkg::cmd_t'(s_axis_tuser) == sawarq_pkg::CMD_ACK ||
                            sawarq_pkg::cmd_t'(s_axis_tuser) == sawarq_pkg::CMD_DATA ||
                            sawarq_pkg::cmd_t'(s_axis_tuser) == sawarq_pkg::CMD_TICK ||
                            sawarq_pkg::cmd_t'(s_axis_tuser) == sawarq_pkg::CMD_ACCEPT)
                            state_reg <= ST_SCAN;
                        else if (sawarq_pkg::cmd_t'(s_axis_tuser) != sawarq_pkg::CMD_NONE)
                            state_reg <= ST_EXEC;
                    end
                end
                ST_SCAN: begin
                    if (cmd_reg == sawarq_pkg::CMD_TICK) begin
                        // a transmit is held in res_reg until the scan knows
                        // whether another one follows, so tlast lands right
                        if (!in_rng || nres_reg == NW'(sawarq_pkg::MAX_RESULTS)) begin
                            if (found_reg)
                                res_reg.last <= 1'b1;
                            else
                                res_reg <= mk(sawarq_pkg::K_IDLE, '0, '0, '0, 1'b1);
                            state_reg <= ST_EMIT;
                        end else if (probe_hit) begin
                            if (found_reg) begin
                                // flush the held transmit, probe this slot again after
                                found_reg <= 1'b0;
                                state_reg <= ST_EMIT;
                            end else begin
                                await_mem[ix] <= 1'b1;
                                lst_mem[ix]   <= now_reg;
                                res_reg <= mk(sawarq_pkg::K_TRANSMIT, addr_mem[ix],
                                              txn_mem[ix] - QSW'(txc_mem[ix]),
                                              3'(idx_reg), 1'b0);
                                found_reg <= 1'b1;
                                nres_reg  <= nres_reg + 1'b1;
                                idx_reg   <= idx_reg + 1'b1;
                            end
                        end else begin
                            idx_reg <= idx_reg + 1'b1;
                        end
                    end else if (!in_rng || probe_hit) begin
                        found_reg <= in_rng;
                        hit_reg   <= ix;
                        state_reg <= ST_EXEC;
                    end else begin
                        idx_reg <= idx_reg + 1'b1;
                    end
                end
                ST_EXEC: begin
                    state_reg <= (cmd_reg == sawarq_pkg::CMD_NONE ||
                                  cmd_reg == sawarq_pkg::CMD_TICK) ? ST_IDLE : ST_EMIT;
                    unique case (cmd_reg)
                        sawarq_pkg::CMD_SYN: begin
                            if (fill_reg < FW'(SYN_DEPTH)) begin
                                syn_mem[wr_ix] <= paddr_reg;
                                fill_reg <= fill_reg + 1'b1;
                                res_reg <= mk(sawarq_pkg::K_SYN_QUEUED, paddr_reg, '0, '0, 1'b1);
                            end else begin
                                res_reg <= mk(sawarq_pkg::K_SYN_DROPPED, paddr_reg, '0, '0, 1'b1);
                            end
                        end
                        sawarq_pkg::CMD_ACK: begin
                            if (!found_reg) begin
                                res_reg <= mk(sawarq_pkg::K_UNKNOWN, paddr_reg, '0, '0, 1'b1);
                            end else begin
                                await_mem[hit_reg] <= 1'b0;
                                if (txc_mem[hit_reg] != '0)
                                    txc_mem[hit_reg] <= txc_mem[hit_reg] - 1'b1;
                                res_reg <= mk(sawarq_pkg::K_ACK_TAKEN, paddr_reg,
                                    (txc_mem[hit_reg] != '0) ?
                                        txn_mem[hit_reg] - QSW'(txc_mem[hit_reg]) : '0,
                                    3'(hit_reg), 1'b1);
                            end
                        end
                        sawarq_pkg::CMD_DATA: begin
                            if (!found_reg) begin
                                res_reg <= mk(sawarq_pkg::K_UNKNOWN, paddr_reg, '0, '0, 1'b1);
                            end else begin
                                res2_reg <= mk(sawarq_pkg::K_SEND_ACK, paddr_reg, pseq_reg,
                                               3'(hit_reg), 1'b1);
                                if (pseq_reg >= rxe_mem[hit_reg]) begin
                                    rxe_mem[hit_reg] <= rxe_mem[hit_reg] + 1'b1;
                                    res_reg <= mk(sawarq_pkg::K_DELIVER, paddr_reg, pseq_reg,
                                                  3'(hit_reg), 1'b0);
                                end else begin
                                    res_reg <= mk(sawarq_pkg::K_SEND_ACK, paddr_reg, pseq_reg,
                                                  3'(hit_reg), 1'b1);
                                end
                            end
                        end
                        sawarq_pkg::CMD_SEND: begin
                            if (!cs_ok) begin
                                res_reg <= mk(sawarq_pkg::K_SEND_REJ, '0, '0, cs_q, 1'b1);
                            end else if (txc_mem[cs_ix] >= TW'(TX_DEPTH)) begin
                                res_reg <= mk(sawarq_pkg::K_SEND_REJ, addr_mem[cs_ix], '0,
                                              cs_q, 1'b1);
                            end else begin
                                txn_mem[cs_ix] <= txn_mem[cs_ix] + 1'b1;
                                txc_mem[cs_ix] <= txc_mem[cs_ix] + 1'b1;
                                res_reg <= mk(sawarq_pkg::K_QUEUED, addr_mem[cs_ix],
                                              txn_mem[cs_ix], cs_q, 1'b1);
                            end
                        end
                        sawarq_pkg::CMD_ACCEPT: begin
                            if (fill_reg == '0) begin
                                res_reg <= mk(sawarq_pkg::K_NONE_PEND, '0, '0, '0, 1'b1);
                            end else if (!found_reg) begin
                                res_reg <= mk(sawarq_pkg::K_TABLE_FULL, '0, '0, '0, 1'b1);
                            end else begin
                                head_reg <= head_inc;
                                fill_reg <= fill_reg - 1'b1;
                                valid_reg[hit_reg] <= 1'b1;
                                addr_mem[hit_reg]  <= syn_mem[head_reg];
                                rxe_mem[hit_reg]   <= sawarq_pkg::START_SEQ;
                                txn_mem[hit_reg]   <= sawarq_pkg::START_SEQ;
                                txc_mem[hit_reg]   <= '0;
                                await_mem[hit_reg] <= 1'b0;
                                lst_mem[hit_reg]   <= '0;
                                res_reg <= mk(sawarq_pkg::K_ADMITTED, syn_mem[head_reg],
                                              sawarq_pkg::START_SEQ, 3'(hit_reg), 1'b1);
                            end
                        end
                        sawarq_pkg::CMD_CLOSE: begin
                            if (!cs_ok) begin
                                res_reg <= mk(sawarq_pkg::K_CLOSE_REJ, '0, '0, cs_q, 1'b1);
                            end else begin
                                valid_reg[cs_ix] <= 1'b0;
                                res_reg <= mk(sawarq_pkg::K_CLOSED, addr_mem[cs_ix], '0,
                                              cs_q, 1'b1);
                            end
                        end
                        default: ;
                    endcase
                end
                ST_EMIT: begin
                    if (res_ready) begin
                        if (cmd_reg == sawarq_pkg::CMD_TICK && !res_reg.last)
                            state_reg <= ST_SCAN;
                        else if (!res_reg.last)
                            state_reg <= ST_EMIT2;
                        else
                            state_reg <= ST_IDLE;
                    end
                end
                ST_EMIT2: begin
                    if (res_ready) state_reg <= ST_IDLE;
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    logic cmd_take;
    assign cmd_take = s_axis_tvalid && s_axis_tready &&
                      (s_axis_tuser != sawarq_pkg::CMD_NONE);

    `include "stop_and_wait_arq_server_unit_defines.svh"
    `SAW_ASSERT_IMP(a_busy_no_ready, aclk, aresetn, state_reg != ST_IDLE, !s_axis_tready)
    `SAW_ASSERT_IMP(a_fill_bound, aclk, aresetn, 1'b1, fill_reg <= FW'(SYN_DEPTH))
    `SAW_ASSERT_NXT(a_accept_busy, aclk, aresetn, cmd_take, state_reg != ST_IDLE)
endmodule
`default_nettype wire

### bench/tb_stop_and_wait_arq_server_unit.sv
`timescale 1ns / 1ps
module tb_stop_and_wait_arq_server_unit;

    localparam int NCLI  = 8;
    localparam int TXMAX = 16;
    localparam int SYNMAX = 4;
    localparam int EXPQ  = 256;
    localparam int LIMIT = 400000;

    class arq_scoreboard;
        bit              in_use [NCLI];
        logic [47:0]     peer   [NCLI];
        logic [31:0]     rx_next[NCLI];
        logic [31:0]     tx_seq [NCLI];
        logic [4:0]      tx_fill[NCLI];
        bit              waiting[NCLI];
        logic [31:0]     sent_at[NCLI];
        logic [47:0]     syn_buf[SYNMAX];
        int              syn_head;
        int              syn_cnt;
        logic [31:0]     clock_ms;
        logic [15:0]     timeout_ms;
        sawarq_pkg::result_t exp_buf[EXPQ];
        int              exp_rd;
        int              exp_wr;
        int              errors;

        function void clear();
            foreach (in_use[i]) in_use[i] = 0;
            syn_head = 0;
            syn_cnt = 0;
            exp_rd = 0;
            exp_wr = 0;
            clock_ms = 0;
            timeout_ms = sawarq_pkg::RESET_TIMEOUT;
            errors = 0;
        endfunction

        function int pending();
            return exp_wr - exp_rd;
        endfunction

        function void add(sawarq_pkg::kind_t k, logic [47:0] a, logic [31:0] s,
                          logic [2:0] sl);
            sawarq_pkg::result_t r;
            r.kind = k;
            r.addr = a;
            r.seq = s;
            r.slot = sl;
            r.last = 0;
            exp_buf[exp_wr % EXPQ] = r;
            exp_wr++;
        endfunction

        function int lookup(logic [47:0] a);
            for (int i = 0; i < NCLI; i++)
                if (in_use[i] && peer[i] == a) return i;
            return -1;
        endfunction

        // predicts the results of one accepted command item
        function void note_cmd(sawarq_pkg::cmd_t c, logic [47:0] a, logic [31:0] s,
                               logic [2:0] sl);
            int n0;
            int idx;
            int sent;
            n0 = exp_wr;
            case (c)
                sawarq_pkg::CMD_SYN: begin
                    if (syn_cnt < SYNMAX) begin
                        syn_buf[(syn_head + syn_cnt) % SYNMAX] = a;
                        syn_cnt++;
                        add(sawarq_pkg::K_SYN_QUEUED, a, 0, 0);
                    end else add(sawarq_pkg::K_SYN_DROPPED, a, 0, 0);
                end
                sawarq_pkg::CMD_ACK: begin
                    idx = lookup(a);
                    if (idx < 0) add(sawarq_pkg::K_UNKNOWN, a, 0, 0);
                    else begin
                        logic [31:0] popped;
                        popped = 0;
                        waiting[idx] = 0;
                        if (tx_fill[idx] != 0) begin
                            popped = tx_seq[idx] - 32'(tx_fill[idx]);
                            tx_fill[idx]--;
                        end
                        add(sawarq_pkg::K_ACK_TAKEN, a, popped, idx[2:0]);
                    end
                end
                sawarq_pkg::CMD_DATA: begin
                    idx = lookup(a);
                    if (idx < 0) add(sawarq_pkg::K_UNKNOWN, a, 0, 0);
                    else begin
                        if (s >= rx_next[idx]) begin
                            add(sawarq_pkg::K_DELIVER, a, s, idx[2:0]);
                            rx_next[idx]++;
                        end
                        add(sawarq_pkg::K_SEND_ACK, a, s, idx[2:0]);
                    end
                end
                sawarq_pkg::CMD_TICK: begin
                    clock_ms++;
                    sent = 0;
                    for (int i = 0; i < NCLI && sent < sawarq_pkg::MAX_RESULTS; i++) begin
                        if (!in_use[i] || tx_fill[i] == 0) continue;
                        if (!waiting[i] || (clock_ms - sent_at[i]) >= 32'(timeout_ms)) begin
                            waiting[i] = 1;
                            sent_at[i] = clock_ms;
                            add(sawarq_pkg::K_TRANSMIT, peer[i], tx_seq[i] - 32'(tx_fill[i]),
                                i[2:0]);
                            sent++;
                        end
                    end
                    if (sent == 0) add(sawarq_pkg::K_IDLE, 0, 0, 0);
                end
                sawarq_pkg::CMD_SEND: begin
                    if (!in_use[sl]) add(sawarq_pkg::K_SEND_REJ, 0, 0, sl);
                    else if (tx_fill[sl] >= TXMAX) add(sawarq_pkg::K_SEND_REJ, peer[sl], 0, sl);
                    else begin
                        add(sawarq_pkg::K_QUEUED, peer[sl], tx_seq[sl], sl);
                        tx_seq[sl]++;
                        tx_fill[sl]++;
                    end
                end
                sawarq_pkg::CMD_ACCEPT: begin
                    idx = -1;
                    for (int i = NCLI - 1; i >= 0; i--)
                        if (!in_use[i]) idx = i;
                    if (syn_cnt == 0) add(sawarq_pkg::K_NONE_PEND, 0, 0, 0);
                    else if (idx < 0) add(sawarq_pkg::K_TABLE_FULL, 0, 0, 0);
                    else begin
                        peer[idx] = syn_buf[syn_head];
                        syn_head = (syn_head + 1) % SYNMAX;
                        syn_cnt--;
                        in_use[idx] = 1;
                        rx_next[idx] = sawarq_pkg::START_SEQ;
                        tx_seq[idx] = sawarq_pkg::START_SEQ;
                        tx_fill[idx] = 0;
                        waiting[idx] = 0;
                        sent_at[idx] = 0;
                        add(sawarq_pkg::K_ADMITTED, peer[idx], sawarq_pkg::START_SEQ, idx[2:0]);
                    end
                end
                sawarq_pkg::CMD_CLOSE: begin
                    if (!in_use[sl]) add(sawarq_pkg::K_CLOSE_REJ, 0, 0, sl);
                    else begin
                        in_use[sl] = 0;
                        add(sawarq_pkg::K_CLOSED, peer[sl], 0, sl);
                    end
                end
                default: ;
            endcase
            if (exp_wr > n0) exp_buf[(exp_wr - 1) % EXPQ].last = 1;
        endfunction

        function void check_result(logic [3:0] k, logic [47:0] a, logic [31:0] s,
                                   logic [2:0] sl, logic l);
            sawarq_pkg::result_t e;
            if (pending() == 0) begin
                $display("%0t: unexpected result kind=%0d addr=%h seq=%h slot=%0d last=%b",
                         $time, k, a, s, sl, l);
                errors++;
                return;
            end
            e = exp_buf[exp_rd % EXPQ];
            exp_rd++;
            if (k !== e.kind) begin
                $display("%0t: kind exp %0d got %0d", $time, e.kind, k);
                errors++;
            end
            if (a !== e.addr) begin
                $display("%0t: addr exp %h got %h", $time, e.addr, a);
                errors++;
            end
            if (s !== e.seq) begin
                $display("%0t: seq exp %h got %h", $time, e.seq, s);
                errors++;
            end
            if (sl !== e.slot) begin
                $display("%0t: slot exp %0d got %0d", $time, e.slot, sl);
                errors++;
            end
            if (l !== e.last) begin
                $display("%0t: last exp %b got %b", $time, e.last, l);
                errors++;
            end
        endfunction
    endclass

    logic        aclk = 0;
    logic        aresetn = 0;
    logic        s_axis_tvalid = 0;
    logic        s_axis_tready;
    logic [87:0] s_axis_tdata = '0;
    logic [2:0]  s_axis_tuser = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 0;
    logic [87:0] m_axis_tdata;
    logic [3:0]  m_axis_tuser;
    logic        m_axis_tlast;
    logic        cfg_we = 0;
    logic [15:0] cfg_wdata = '0;

    arq_scoreboard sb = new();
    int          cycles = 0;
    int          results_seen = 0;
    int          burst_left = 0;
    logic [47:0] addr_pool[10];

    stop_and_wait_arq_server_unit u_dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser),
        .m_axis_tlast(m_axis_tlast),
        .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
    );

    always #10 aclk = ~aclk;

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT) begin
            $display("tb_stop_and_wait_arq_server_unit: FAIL");
            $finish;
        end
    end

    // result monitor
    always @(posedge aclk) begin
        if (aresetn && m_axis_tvalid && m_axis_tready) begin
            sb.check_result(m_axis_tuser, m_axis_tdata[47:0], m_axis_tdata[79:48],
                            m_axis_tdata[82:80], m_axis_tlast);
            results_seen <= results_seen + 1;
        end
    end

    // receiver stall pattern, one long hold-off once results are flowing
    int  hold_left = 0;
    bit  hold_done = 0;
    int  mode_left = 0;
    int  stall_pct = 0;
    always @(posedge aclk) begin
        if (!hold_done && results_seen >= 60) begin
            hold_done <= 1;
            hold_left <= 500;
            m_axis_tready <= 0;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            m_axis_tready <= (hold_left == 1);
        end else begin
            if (mode_left == 0) begin
                mode_left <= $urandom_range(20, 120);
                stall_pct <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(10, 70);
            end else mode_left <= mode_left - 1;
            m_axis_tready <= ($urandom_range(0, 99) >= stall_pct);
        end
    end

    task automatic push_cmd(sawarq_pkg::cmd_t c, logic [47:0] a, logic [31:0] s,
                            logic [2:0] sl);
        int gap;
        s_axis_tvalid <= 1;
        s_axis_tuser <= c;
        s_axis_tdata <= {5'b0, sl, s, a};
        do @(posedge aclk); while (!s_axis_tready);
        sb.note_cmd(c, a, s, sl);
        if (burst_left > 0) burst_left--;
        else begin
            burst_left = $urandom_range(0, 12);
            gap = $urandom_range(1, 10);
            s_axis_tvalid <= 0;
            repeat (gap) @(posedge aclk);
        end
    endtask

    task automatic settle();
        s_axis_tvalid <= 0;
        burst_left = 0;
        while (sb.pending() != 0) @(posedge aclk);
        // a trailing ignored command may still be in flight
        repeat (40) @(posedge aclk);
    endtask

    task automatic set_timeout(logic [15:0] v);
        settle();
        cfg_we <= 1;
        cfg_wdata <= v;
        @(posedge aclk);
        sb.timeout_ms = v;
        cfg_we <= 0;
    endtask

    task automatic random_cmd();
        int r;
        logic [47:0] a;
        logic [31:0] s;
        r = $urandom_range(0, 99);
        a = addr_pool[$urandom_range(0, 9)];
        s = ($urandom_range(0, 9) < 7) ? 32'($urandom_range(0, 12)) : $urandom;
        if (r < 12)
            push_cmd(sawarq_pkg::CMD_SYN,
                     ($urandom_range(0, 19) == 0) ? 48'({$urandom, $urandom}) : a,
                     $urandom, 3'($urandom));
        else if (r < 22)
            push_cmd(sawarq_pkg::CMD_ACCEPT, 48'({$urandom, $urandom}), $urandom,
                     3'($urandom));
        else if (r < 36)
            push_cmd(sawarq_pkg::CMD_SEND, 48'({$urandom, $urandom}), $urandom,
                     3'($urandom));
        else if (r < 55)
            push_cmd(sawarq_pkg::CMD_TICK, 48'({$urandom, $urandom}), $urandom,
                     3'($urandom));
        else if (r < 70) push_cmd(sawarq_pkg::CMD_DATA, a, s, 3'($urandom));
        else if (r < 82) push_cmd(sawarq_pkg::CMD_ACK, a, $urandom, 3'($urandom));
        else if (r < 87) push_cmd(sawarq_pkg::CMD_CLOSE, a, $urandom, 3'($urandom));
        else if (r < 90)
            push_cmd(sawarq_pkg::CMD_NONE, 48'({$urandom, $urandom}), $urandom,
                     3'($urandom));
        else
            push_cmd(($urandom_range(0, 1) != 0) ? sawarq_pkg::CMD_ACK : sawarq_pkg::CMD_DATA,
                     48'({$urandom, $urandom}), $urandom, 3'($urandom));
    endtask

    initial begin
        logic [15:0] tmo_list[5];
        sb.clear();
        addr_pool[0] = '0;
        addr_pool[1] = '1;
        for (int i = 2; i < 10; i++) addr_pool[i] = 48'({$urandom, $urandom});
        repeat (12) @(posedge aclk);
        aresetn <= 1;
        @(posedge aclk);

        // directed
        push_cmd(sawarq_pkg::CMD_ACCEPT, '0, '0, '0);
        push_cmd(sawarq_pkg::CMD_ACK, '0, '0, '0);
        push_cmd(sawarq_pkg::CMD_DATA, '1, '1, '1);
        push_cmd(sawarq_pkg::CMD_TICK, '0, '0, '0);
        push_cmd(sawarq_pkg::CMD_SEND, '0, '0, 3'd7);
        push_cmd(sawarq_pkg::CMD_CLOSE, '0, '0, 3'd5);
        push_cmd(sawarq_pkg::CMD_SYN, addr_pool[0], '0, '0);
        push_cmd(sawarq_pkg::CMD_SYN, addr_pool[1], '0, '0);
        push_cmd(sawarq_pkg::CMD_SYN, addr_pool[2], '0, '0);
        push_cmd(sawarq_pkg::CMD_SYN, addr_pool[0], '0, '0);
        push_cmd(sawarq_pkg::CMD_SYN, addr_pool[3], '0, '0);
        push_cmd(sawarq_pkg::CMD_ACCEPT, '0, '0, '0);
        push_cmd(sawarq_pkg::CMD_ACCEPT, '0, '0, '0);
        push_cmd(sawarq_pkg::CMD_SEND, '0, '0, 3'd0);
        push_cmd(sawarq_pkg::CMD_TICK, '0, '0, '0);
        push_cmd(sawarq_pkg::CMD_ACK, addr_pool[0], '0, '0);
        push_cmd(sawarq_pkg::CMD_ACK, addr_pool[0], '0, '0);
        push_cmd(sawarq_pkg::CMD_DATA, addr_pool[0], 32'd1, '0);
        push_cmd(sawarq_pkg::CMD_DATA, addr_pool[0], 32'd0, '0);
        push_cmd(sawarq_pkg::CMD_DATA, addr_pool[1], 32'hFFFF_FFFF, '0);
        push_cmd(sawarq_pkg::CMD_CLOSE, '0, '0, 3'd1);
        push_cmd(sawarq_pkg::CMD_NONE, '1, '1, '1);
        push_cmd(sawarq_pkg::CMD_ACCEPT, '0, '0, '0);
        push_cmd(sawarq_pkg::CMD_ACCEPT, '0, '0, '0);
        push_cmd(sawarq_pkg::CMD_ACK, addr_pool[0], '0, '0);

        tmo_list[0] = 16'd1;
        tmo_list[1] = 16'hFFFF;
        tmo_list[2] = 16'd3;
        tmo_list[3] = 16'($urandom_range(2, 8));
        tmo_list[4] = 16'd1;
        foreach (tmo_list[p]) begin
            set_timeout(tmo_list[p]);
            repeat (42) random_cmd();
        end

        settle();
        if (sb.errors == 0) $display("tb_stop_and_wait_arq_server_unit: PASS");
        else $display("tb_stop_and_wait_arq_server_unit: FAIL");
        $finish;
    end
endmodule

### sim.f
+incdir+hw/rtl
hw/rtl/sawarq_pkg.sv
hw/rtl/sawarq_out_reg.sv
hw/rtl/stop_and_wait_arq_server_unit.sv
bench/tb_stop_and_wait_arq_server_unit.sv
